/* hw/rtl/calendar_event_queue_macros.svh */
// assertion macros shared by the calendar event queue rtl
`ifndef CALENDAR_EVENT_QUEUE_MACROS_SVH
`define CALENDAR_EVENT_QUEUE_MACROS_SVH

// property that holds at every clock edge out of reset
`define CQ_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define CQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/cq_pkg.sv */
// types, constants and helper functions of the calendar event queue
`default_nettype none
package cq_pkg;
	localparam int CAPACITY    = 512;
	localparam int MAX_BUCKETS = 256;
	localparam int FRAC_BITS   = 16;
	localparam int TAG_BITS    = 32;
	localparam int TIME_W      = 48;
	localparam int PAY_W       = 32;
	localparam int STAT_W      = 2;
	localparam int SLOT_W      = $clog2(CAPACITY);
	localparam int PTR_W       = SLOT_W + 1;
	localparam int CNT_W       = 10;
	localparam int BKT_W       = $clog2(MAX_BUCKETS);
	localparam int MAX_LOG     = BKT_W;
	localparam int LOG_W       = 4;
	localparam int YEAR_W      = TIME_W - FRAC_BITS;

	typedef logic [TIME_W-1:0]   time_t;
	typedef logic [TAG_BITS-1:0] tag_t;
	typedef logic [PTR_W-1:0]    ptr_t;
	typedef logic [SLOT_W-1:0]   slot_t;
	typedef logic [BKT_W-1:0]    bkt_t;
	typedef logic [LOG_W-1:0]    log_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [YEAR_W-1:0]   year_t;

	localparam ptr_t NIL = ptr_t'(CAPACITY);

	localparam logic CMD_SCHEDULE = 1'b0;
	localparam logic CMD_REMOVE   = 1'b1;

	localparam logic [STAT_W-1:0] ST_SCHEDULED = 2'd0;
	localparam logic [STAT_W-1:0] ST_REMOVED   = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

	function automatic bkt_t bkt_mask(input log_t l);
		logic [BKT_W:0] m;
		m = ((BKT_W+1)'(1) << l) - (BKT_W+1)'(1);
		return m[BKT_W-1:0];
	endfunction

	function automatic bkt_t bucket_of(input time_t t, input log_t l);
		time_t sh;
		sh = t >> (FRAC_BITS - int'(l));
		return sh[BKT_W-1:0] & bkt_mask(l);
	endfunction

	function automatic year_t sat_inc(input year_t y);
		return (y == '1) ? y : y + year_t'(1);
	endfunction
endpackage
`default_nettype wire

/* hw/rtl/cq_in_if.sv */
// request channel: command, timestamp and tag
`default_nettype none
interface cq_in_if;
	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic [cq_pkg::TIME_W-1:0] event_time;
	logic [cq_pkg::PAY_W-1:0]  event_payload;

	modport source (output valid, cmd, event_time, event_payload, input ready);
	modport sink   (input valid, cmd, event_time, event_payload, output ready);
endinterface
`default_nettype wire

/* hw/rtl/cq_out_if.sv */
// result channel: status, removed event and fill level
`default_nettype none
interface cq_out_if;
	logic                      valid;
	logic                      ready;
	logic [cq_pkg::STAT_W-1:0] status;
	logic [cq_pkg::TIME_W-1:0] out_time;
	logic [cq_pkg::PAY_W-1:0]  out_payload;
	logic [cq_pkg::CNT_W-1:0]  pending_count;

	modport source (output valid, status, out_time, out_payload, pending_count, input ready);
	modport sink   (input valid, status, out_time, out_payload, pending_count, output ready);
endinterface
`default_nettype wire

/* hw/rtl/calendar_event_queue.sv */
// calendar queue event list: bucketed sorted lists in block memories
//
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   cmd, event_time, event_payload
//  out_ch   out  valid/ready   status, out_time, out_payload, pending_count
//
// one request at a time; a schedule walks the sorted list of its bucket to find its place
// a remove scans buckets from its last point; failing that, a fallback search takes the minimum head
// a resize walks all lists, then reinserts each event with the same sorted insert
// and runs one more head search over all buckets; all of it is bound by the single memory read port
// reset clears control state and the bucket valid bits at once; no clearing pass
// the next request is taken while a result still waits on out_ch
`default_nettype none
`include "calendar_event_queue_macros.svh"
module calendar_event_queue (
	input wire logic  clk,
	input wire logic  arst_n,
	cq_in_if.sink     in_ch,
	cq_out_if.source  out_ch
);
	typedef enum logic [19:0] {
		S_IDLE      = 20'd1 << 0,
		S_ALLOC     = 20'd1 << 1,
		S_INS_HEAD  = 20'd1 << 2,
		S_INS_HWAIT = 20'd1 << 3,
		S_INS_WALK  = 20'd1 << 4,
		S_INS_LINK  = 20'd1 << 5,
		S_INS_FIX   = 20'd1 << 6,
		S_SCAN      = 20'd1 << 7,
		S_MIN       = 20'd1 << 8,
		S_MIN_END   = 20'd1 << 9,
		S_POP_RD    = 20'd1 << 10,
		S_POP_WR    = 20'd1 << 11,
		S_RC_HEAD   = 20'd1 << 12,
		S_RC_HWAIT  = 20'd1 << 13,
		S_RC_LINK   = 20'd1 << 14,
		S_RC_DONE   = 20'd1 << 15,
		S_RH_ORD    = 20'd1 << 16,
		S_RH_SLOT   = 20'd1 << 17,
		S_RH_TIME   = 20'd1 << 18,
		S_DONE      = 20'd1 << 19
	} state_t;

	// memories
	cq_pkg::time_t time_mem [cq_pkg::CAPACITY];
	cq_pkg::tag_t  tag_mem  [cq_pkg::CAPACITY];
	cq_pkg::ptr_t  link_mem [cq_pkg::CAPACITY];
	cq_pkg::slot_t ord_mem  [cq_pkg::CAPACITY];
	cq_pkg::ptr_t  head_mem [cq_pkg::MAX_BUCKETS];
	logic [cq_pkg::MAX_BUCKETS-1:0] head_vld_q;

	cq_pkg::slot_t time_ra, tag_ra, link_ra, ord_ra;
	cq_pkg::bkt_t  head_ra;
	cq_pkg::time_t time_rd;
	cq_pkg::tag_t  tag_rd;
	cq_pkg::ptr_t  link_rd, head_rd;
	cq_pkg::slot_t ord_rd;
	logic          head_hv_rd;

	logic          time_we, tag_we, link_we, head_we, ord_we;
	cq_pkg::slot_t time_wa, link_wa, ord_wa;
	cq_pkg::bkt_t  head_wa;
	cq_pkg::time_t time_wd;
	cq_pkg::tag_t  tag_wd;
	cq_pkg::ptr_t  link_wd, head_wd;
	cq_pkg::slot_t ord_wd;

	// control and datapath registers
	state_t        state_q;
	logic          resizing_q, min_resize_q;
	cq_pkg::slot_t ins_s_q;
	cq_pkg::time_t ins_t_q;
	cq_pkg::bkt_t  ins_b_q;
	cq_pkg::ptr_t  ins_p_q, ins_prev_q;
	cq_pkg::ptr_t  free_head_q, wm_q;
	cq_pkg::cnt_t  count_q, cnt_q, rk_q;
	cq_pkg::log_t  log_q, new_log_q;
	cq_pkg::bkt_t  scan_start_q, start_q, rc_j_q;
	cq_pkg::year_t round_q;
	cq_pkg::bkt_t  iss_idx_q, idx_s1, idx_s2;
	logic          iss_on_q, v_s1, v_s2;
	cq_pkg::ptr_t  head_s2;
	logic          best_v_q;
	cq_pkg::time_t best_t_q;
	cq_pkg::bkt_t  best_b_q, pop_b_q;
	cq_pkg::slot_t best_s_q, pop_s_q;
	logic [cq_pkg::STAT_W-1:0] res_status_q, out_status_q;
	cq_pkg::time_t res_time_q, out_time_q;
	cq_pkg::tag_t  res_tag_q, out_tag_q;
	cq_pkg::cnt_t  out_count_q;
	logic          out_valid_q;

	// derived
	logic          in_fire, full, pipe_on, found, grow, shrink, min_better;
	cq_pkg::bkt_t  nmask, ins_bkt, next_idx;
	cq_pkg::ptr_t  head_ptr, rc_ptr;
	cq_pkg::cnt_t  count_dec;

	assign in_ch.ready   = (state_q == S_IDLE);
	assign in_fire       = in_ch.valid && in_ch.ready;
	assign full          = (count_q >= cq_pkg::CNT_W'(cq_pkg::CAPACITY)) ||
	                       (free_head_q >= cq_pkg::NIL);
	assign nmask         = cq_pkg::bkt_mask(log_q);
	assign ins_bkt       = cq_pkg::bucket_of(ins_t_q, log_q);
	assign head_ptr      = head_hv_rd ? head_rd : cq_pkg::NIL;
	assign rc_ptr        = (state_q == S_RC_HWAIT) ? head_ptr : link_rd;
	assign pipe_on       = (state_q == S_SCAN) || (state_q == S_MIN);
	assign next_idx      = (idx_s2 + cq_pkg::bkt_t'(1)) & nmask;
	assign found         = (head_s2 != cq_pkg::NIL) &&
	                       (time_rd[cq_pkg::TIME_W-1:cq_pkg::FRAC_BITS] < round_q);
	assign min_better    = (head_s2 != cq_pkg::NIL) && (!best_v_q || time_rd < best_t_q);
	assign count_dec     = count_q - cq_pkg::cnt_t'(1);
	assign grow          = ({1'b0, count_q} > ((cq_pkg::CNT_W+1)'(2) << log_q)) &&
	                       (log_q < cq_pkg::log_t'(cq_pkg::MAX_LOG));
	assign shrink        = (log_q != '0) &&
	                       ({1'b0, count_dec} < (((cq_pkg::CNT_W+1)'(1) << log_q) >> 1));

	assign out_ch.valid         = out_valid_q;
	assign out_ch.status        = out_status_q;
	assign out_ch.out_time      = out_time_q;
	assign out_ch.out_payload   = cq_pkg::PAY_W'(out_tag_q);
	assign out_ch.pending_count = out_count_q;

	// memory ports
	always_ff @(posedge clk) begin
		if (time_we) time_mem[time_wa] <= time_wd;
		if (tag_we)  tag_mem[time_wa]  <= tag_wd;
		if (link_we) link_mem[link_wa] <= link_wd;
		if (head_we) head_mem[head_wa] <= head_wd;
		if (ord_we)  ord_mem[ord_wa]   <= ord_wd;
		time_rd    <= time_mem[time_ra];
		tag_rd     <= tag_mem[tag_ra];
		link_rd    <= link_mem[link_ra];
		head_rd    <= head_mem[head_ra];
		ord_rd     <= ord_mem[ord_ra];
		head_hv_rd <= head_vld_q[head_ra];
	end

	always_comb begin
		time_ra = '0;
		tag_ra  = '0;
		link_ra = '0;
		head_ra = '0;
		ord_ra  = '0;
		time_we = 1'b0;
		tag_we  = 1'b0;
		time_wa = free_head_q[cq_pkg::SLOT_W-1:0];
		time_wd = in_ch.event_time;
		tag_wd  = in_ch.event_payload[cq_pkg::TAG_BITS-1:0];
		link_we = 1'b0;
		link_wa = '0;
		link_wd = '0;
		head_we = 1'b0;
		head_wa = '0;
		head_wd = '0;
		ord_we  = 1'b0;
		ord_wa  = cnt_q[cq_pkg::SLOT_W-1:0];
		ord_wd  = rc_ptr[cq_pkg::SLOT_W-1:0];
		if (pipe_on) begin
			head_ra = iss_idx_q;
			time_ra = head_ptr[cq_pkg::SLOT_W-1:0];
		end
		case (state_q)
			S_IDLE: begin
				link_ra = free_head_q[cq_pkg::SLOT_W-1:0];
				if (in_fire && in_ch.cmd == cq_pkg::CMD_SCHEDULE && !full) begin
					time_we = 1'b1;
					tag_we  = 1'b1;
				end
			end
			S_INS_HEAD: head_ra = ins_bkt;
			S_INS_HWAIT: begin
				time_ra = head_ptr[cq_pkg::SLOT_W-1:0];
				link_ra = head_ptr[cq_pkg::SLOT_W-1:0];
			end
			S_INS_WALK: begin
				time_ra = link_rd[cq_pkg::SLOT_W-1:0];
				link_ra = link_rd[cq_pkg::SLOT_W-1:0];
			end
			S_INS_LINK: begin
				link_we = 1'b1;
				link_wa = ins_s_q;
				link_wd = ins_p_q;
				if (ins_prev_q == cq_pkg::NIL) begin
					head_we = 1'b1;
					head_wa = ins_b_q;
					head_wd = cq_pkg::ptr_t'(ins_s_q);
				end
			end
			S_INS_FIX: begin
				if (ins_prev_q != cq_pkg::NIL) begin
					link_we = 1'b1;
					link_wa = ins_prev_q[cq_pkg::SLOT_W-1:0];
					link_wd = cq_pkg::ptr_t'(ins_s_q);
				end
			end
			S_POP_RD: begin
				time_ra = pop_s_q;
				tag_ra  = pop_s_q;
				link_ra = pop_s_q;
			end
			S_POP_WR: begin
				head_we = 1'b1;
				head_wa = pop_b_q;
				head_wd = link_rd;
				link_we = 1'b1;
				link_wa = pop_s_q;
				link_wd = free_head_q;
			end
			S_RC_HEAD: head_ra = rc_j_q;
			S_RC_HWAIT, S_RC_LINK: begin
				if (rc_ptr != cq_pkg::NIL) begin
					ord_we  = 1'b1;
					link_ra = rc_ptr[cq_pkg::SLOT_W-1:0];
				end
			end
			S_RH_ORD: ord_ra = rk_q[cq_pkg::SLOT_W-1:0];
			S_RH_SLOT: time_ra = ord_rd;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_vld_q   <= '0;
			resizing_q   <= 1'b0;
			min_resize_q <= 1'b0;
			ins_s_q      <= '0;
			ins_t_q      <= '0;
			ins_b_q      <= '0;
			ins_p_q      <= cq_pkg::NIL;
			ins_prev_q   <= cq_pkg::NIL;
			free_head_q  <= '0;
			wm_q         <= '0;
			count_q      <= '0;
			cnt_q        <= '0;
			rk_q         <= '0;
			log_q        <= '0;
			new_log_q    <= '0;
			scan_start_q <= '0;
			start_q      <= '0;
			rc_j_q       <= '0;
			round_q      <= cq_pkg::year_t'(1);
			iss_idx_q    <= '0;
			iss_on_q     <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			idx_s1       <= '0;
			idx_s2       <= '0;
			head_s2      <= cq_pkg::NIL;
			best_v_q     <= 1'b0;
			best_t_q     <= '0;
			best_b_q     <= '0;
			best_s_q     <= '0;
			pop_b_q      <= '0;
			pop_s_q      <= '0;
			res_status_q <= cq_pkg::ST_SCHEDULED;
			res_time_q   <= '0;
			res_tag_q    <= '0;
			out_status_q <= cq_pkg::ST_SCHEDULED;
			out_time_q   <= '0;
			out_tag_q    <= '0;
			out_count_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (head_we) head_vld_q[head_wa] <= 1'b1;
			if (out_ch.ready) out_valid_q <= 1'b0;
			// two-stage head pipeline: bucket head, then its timestamp
			v_s1    <= iss_on_q;
			idx_s1  <= iss_idx_q;
			v_s2    <= v_s1;
			idx_s2  <= idx_s1;
			head_s2 <= head_ptr;
			if (iss_on_q) iss_idx_q <= (iss_idx_q + cq_pkg::bkt_t'(1)) & nmask;

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						res_time_q <= '0;
						res_tag_q  <= '0;
						if (in_ch.cmd == cq_pkg::CMD_SCHEDULE) begin
							if (full) begin
								res_status_q <= cq_pkg::ST_FULL;
								state_q      <= S_DONE;
							end else begin
								ins_s_q    <= free_head_q[cq_pkg::SLOT_W-1:0];
								ins_t_q    <= in_ch.event_time;
								resizing_q <= 1'b0;
								state_q    <= S_ALLOC;
							end
						end else if (count_q == '0) begin
							res_status_q <= cq_pkg::ST_EMPTY;
							state_q      <= S_DONE;
						end else begin
							start_q   <= scan_start_q & nmask;
							iss_idx_q <= scan_start_q & nmask;
							iss_on_q  <= 1'b1;
							v_s1      <= 1'b0;
							v_s2      <= 1'b0;
							state_q   <= S_SCAN;
						end
					end
				end
				S_ALLOC: begin
					// slots at or above the mark still hold the initial chain
					if (free_head_q == wm_q) begin
						free_head_q <= free_head_q + cq_pkg::ptr_t'(1);
						wm_q        <= wm_q + cq_pkg::ptr_t'(1);
					end else begin
						free_head_q <= link_rd;
					end
					count_q      <= count_q + cq_pkg::cnt_t'(1);
					res_status_q <= cq_pkg::ST_SCHEDULED;
					state_q      <= S_INS_HEAD;
				end
				S_INS_HEAD: begin
					ins_b_q <= ins_bkt;
					state_q <= S_INS_HWAIT;
				end
				S_INS_HWAIT: begin
					ins_prev_q <= cq_pkg::NIL;
					ins_p_q    <= head_ptr;
					state_q    <= (head_ptr == cq_pkg::NIL) ? S_INS_LINK : S_INS_WALK;
				end
				S_INS_WALK: begin
					if (time_rd < ins_t_q) begin
						ins_prev_q <= ins_p_q;
						ins_p_q    <= link_rd;
						if (link_rd == cq_pkg::NIL) state_q <= S_INS_LINK;
					end else begin
						state_q <= S_INS_LINK;
					end
				end
				S_INS_LINK: state_q <= S_INS_FIX;
				S_INS_FIX: begin
					if (resizing_q) begin
						rk_q <= rk_q + cq_pkg::cnt_t'(1);
						if (rk_q + cq_pkg::cnt_t'(1) == cnt_q) begin
							best_v_q     <= 1'b0;
							iss_idx_q    <= '0;
							iss_on_q     <= 1'b1;
							v_s1         <= 1'b0;
							v_s2         <= 1'b0;
							min_resize_q <= 1'b1;
							state_q      <= S_MIN;
						end else begin
							state_q <= S_RH_ORD;
						end
					end else if (grow) begin
						new_log_q  <= log_q + cq_pkg::log_t'(1);
						rc_j_q     <= '0;
						cnt_q      <= '0;
						resizing_q <= 1'b1;
						state_q    <= S_RC_HEAD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					if (v_s2) begin
						if (found) begin
							pop_b_q  <= idx_s2;
							pop_s_q  <= head_s2[cq_pkg::SLOT_W-1:0];
							iss_on_q <= 1'b0;
							v_s1     <= 1'b0;
							v_s2     <= 1'b0;
							state_q  <= S_POP_RD;
						end else begin
							// wrapping past the last bucket opens the next year
							if (idx_s2 == nmask) round_q <= cq_pkg::sat_inc(round_q);
							if (next_idx == start_q) begin
								best_v_q     <= 1'b0;
								iss_idx_q    <= '0;
								iss_on_q     <= 1'b1;
								v_s1         <= 1'b0;
								v_s2         <= 1'b0;
								min_resize_q <= 1'b0;
								state_q      <= S_MIN;
							end
						end
					end
				end
				S_MIN: begin
					if (iss_on_q && iss_idx_q == nmask) iss_on_q <= 1'b0;
					if (v_s2) begin
						if (min_better) begin
							best_v_q <= 1'b1;
							best_t_q <= time_rd;
							best_b_q <= idx_s2;
							best_s_q <= head_s2[cq_pkg::SLOT_W-1:0];
						end
						if (idx_s2 == nmask) begin
							iss_on_q <= 1'b0;
							v_s1     <= 1'b0;
							v_s2     <= 1'b0;
							state_q  <= S_MIN_END;
						end
					end
				end
				S_MIN_END: begin
					if (min_resize_q) begin
						scan_start_q <= best_v_q ? best_b_q : (scan_start_q & nmask);
						resizing_q   <= 1'b0;
						state_q      <= S_DONE;
					end else begin
						round_q <= cq_pkg::sat_inc(best_t_q[cq_pkg::TIME_W-1:cq_pkg::FRAC_BITS]);
						pop_b_q <= best_b_q;
						pop_s_q <= best_s_q;
						state_q <= S_POP_RD;
					end
				end
				S_POP_RD: state_q <= S_POP_WR;
				S_POP_WR: begin
					free_head_q  <= cq_pkg::ptr_t'(pop_s_q);
					res_status_q <= cq_pkg::ST_REMOVED;
					res_time_q   <= time_rd;
					res_tag_q    <= tag_rd;
					count_q      <= count_dec;
					scan_start_q <= pop_b_q;
					if (shrink) begin
						new_log_q  <= log_q - cq_pkg::log_t'(1);
						rc_j_q     <= '0;
						cnt_q      <= '0;
						resizing_q <= 1'b1;
						state_q    <= S_RC_HEAD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RC_HEAD: state_q <= S_RC_HWAIT;
				S_RC_HWAIT, S_RC_LINK: begin
					// gather every slot in bucket order before rehashing
					if (rc_ptr != cq_pkg::NIL) begin
						cnt_q   <= cnt_q + cq_pkg::cnt_t'(1);
						state_q <= S_RC_LINK;
					end else if (rc_j_q == nmask) begin
						state_q <= S_RC_DONE;
					end else begin
						rc_j_q  <= rc_j_q + cq_pkg::bkt_t'(1);
						state_q <= S_RC_HEAD;
					end
				end
				S_RC_DONE: begin
					head_vld_q <= '0;
					log_q      <= new_log_q;
					rk_q       <= '0;
					if (cnt_q == '0) begin
						best_v_q     <= 1'b0;
						iss_idx_q    <= '0;
						iss_on_q     <= 1'b1;
						v_s1         <= 1'b0;
						v_s2         <= 1'b0;
						min_resize_q <= 1'b1;
						state_q      <= S_MIN;
					end else begin
						state_q <= S_RH_ORD;
					end
				end
				S_RH_ORD: state_q <= S_RH_SLOT;
				S_RH_SLOT: begin
					ins_s_q <= ord_rd;
					state_q <= S_RH_TIME;
				end
				S_RH_TIME: begin
					ins_t_q <= time_rd;
					state_q <= S_INS_HEAD;
				end
				S_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_time_q   <= res_time_q;
						out_tag_q    <= res_tag_q;
						out_count_q  <= count_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`CQ_ASSERT_ALWAYS(a_count_bound, count_q <= cq_pkg::cnt_t'(cq_pkg::CAPACITY), "count overflow")
	`CQ_ASSERT_ALWAYS(a_free_mark, free_head_q <= wm_q, "free head beyond fill mark")
	`CQ_ASSERT_ALWAYS(a_log_bound, log_q <= cq_pkg::log_t'(cq_pkg::MAX_LOG), "bucket log too big")
	`CQ_ASSERT_NEXT(a_empty_remove, in_fire && in_ch.cmd == cq_pkg::CMD_REMOVE && count_q == '0, state_q == S_DONE && res_status_q == cq_pkg::ST_EMPTY, "empty remove not flagged")
endmodule
`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for the calendar event queue
`timescale 1ns / 100ps
module testbench;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT  = 400000;
	localparam int NONE        = cq_pkg::CAPACITY;

	typedef struct packed {
		logic [cq_pkg::STAT_W-1:0] status;
		cq_pkg::time_t             out_time;
		logic [cq_pkg::PAY_W-1:0]  out_payload;
		cq_pkg::cnt_t              pending_count;
	} outcome_t;

	class event_list_sb;
		cq_pkg::time_t ev_time[cq_pkg::CAPACITY];
		cq_pkg::tag_t  ev_tag[cq_pkg::CAPACITY];
		int            ev_next[cq_pkg::CAPACITY];
		int            first[cq_pkg::MAX_BUCKETS];
		int            free_head, held, blog, scan_start;
		logic [31:0]   round_top;
		cq_pkg::time_t last_time;
		outcome_t      pending[$];
		int            errors, checked, n_removed, n_empty, n_full, n_resize;

		function new();
			for (int i = 0; i < cq_pkg::CAPACITY; i++) ev_next[i] = i + 1;
			for (int i = 0; i < cq_pkg::MAX_BUCKETS; i++) first[i] = NONE;
			free_head = 0;
			held = 0;
			blog = 0;
			scan_start = 0;
			round_top = 1;
			last_time = '0;
		endfunction

		function int home_bucket(cq_pkg::time_t t);
			cq_pkg::time_t sh;
			sh = t >> (cq_pkg::FRAC_BITS - blog);
			return int'(sh[15:0]) & ((1 << blog) - 1);
		endfunction

		function void link_in(int s);
			int b, prev, p;
			b = home_bucket(ev_time[s]);
			prev = NONE;
			p = first[b];
			while (p != NONE && ev_time[p] < ev_time[s]) begin
				prev = p;
				p = ev_next[p];
			end
			ev_next[s] = p;
			if (prev == NONE) first[b] = s;
			else ev_next[prev] = s;
		endfunction

		function void rehash(int new_log);
			int order[$];
			int best, bestb, p;
			for (int j = 0; j < (1 << blog); j++)
				for (p = first[j]; p != NONE; p = ev_next[p]) order.push_back(p);
			for (int j = 0; j < cq_pkg::MAX_BUCKETS; j++) first[j] = NONE;
			blog = new_log;
			n_resize++;
			foreach (order[k]) link_in(order[k]);
			best = NONE;
			bestb = 0;
			for (int j = 0; j < (1 << blog); j++) begin
				p = first[j];
				if (p != NONE && (best == NONE || ev_time[p] < ev_time[best])) begin
					best = p;
					bestb = j;
				end
			end
			if (best == NONE) scan_start &= (1 << blog) - 1;
			else scan_start = bestb;
		endfunction

		function void note_input(logic cmd, cq_pkg::time_t t, logic [cq_pkg::PAY_W-1:0] pay);
			outcome_t r;
			int n, s, i, start, guard, best;
			bit found;
			n = 1 << blog;
			r = '0;
			if (cmd == cq_pkg::CMD_SCHEDULE) begin
				if (held >= cq_pkg::CAPACITY || free_head >= NONE) begin
					r.status = cq_pkg::ST_FULL;
					n_full++;
				end else begin
					s = free_head;
					free_head = ev_next[s];
					ev_time[s] = t;
					ev_tag[s] = pay;
					link_in(s);
					held++;
					if (held > 2 * n && blog < cq_pkg::MAX_LOG) rehash(blog + 1);
					r.status = cq_pkg::ST_SCHEDULED;
				end
			end else if (held == 0) begin
				r.status = cq_pkg::ST_EMPTY;
				n_empty++;
			end else begin
				start = scan_start & (n - 1);
				i = start;
				found = 0;
				for (guard = 0; guard <= n; guard++) begin
					s = first[i];
					if (s != NONE &&
						(ev_time[s] >> cq_pkg::FRAC_BITS) < {16'd0, round_top}) begin
						found = 1;
						break;
					end
					i++;
					if (i == n) begin
						i = 0;
						if (round_top != '1) round_top++;
					end
					if (i == start) break;
				end
				if (!found) begin
					best = NONE;
					for (int j = 0; j < n; j++) begin
						s = first[j];
						if (s != NONE && (best == NONE || ev_time[s] < ev_time[best])) begin
							best = s;
							i = j;
						end
					end
					round_top = ev_time[best][47:16];
					if (round_top != '1) round_top++;
				end
				s = first[i];
				first[i] = ev_next[s];
				ev_next[s] = free_head;
				free_head = s;
				r.out_time = ev_time[s];
				r.out_payload = ev_tag[s];
				held--;
				scan_start = i;
				last_time = ev_time[s];
				if (held < n / 2) rehash(blog - 1);
				r.status = cq_pkg::ST_REMOVED;
				n_removed++;
			end
			r.pending_count = cq_pkg::cnt_t'(held);
			pending.push_back(r);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(outcome_t got);
			outcome_t w;
			checked++;
			if (pending.size() == 0) begin
				report("result with nothing expected");
				return;
			end
			w = pending.pop_front();
			if (got.status != w.status)
				report($sformatf("status %0d, expected %0d", got.status, w.status));
			if (got.out_time != w.out_time)
				report($sformatf("out_time %h, expected %h", got.out_time, w.out_time));
			if (got.out_payload != w.out_payload)
				report($sformatf("out_payload %h, expected %h", got.out_payload,
					w.out_payload));
			if (got.pending_count != w.pending_count)
				report($sformatf("pending_count %0d, expected %0d", got.pending_count,
					w.pending_count));
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   no_idle;
	bit   hold_req;
	int   idle_cycles;
	event_list_sb sb;

	cq_in_if  in_ch();
	cq_out_if out_ch();

	calendar_event_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// sender: one item per call, valid stays high across back-to-back items
	task automatic send_item(logic cmd, cq_pkg::time_t t, logic [cq_pkg::PAY_W-1:0] pay);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.cmd           <= cmd;
		in_ch.event_time    <= t;
		in_ch.event_payload <= pay;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_input(cmd, t, pay);
	endtask

	task automatic schedule_at(cq_pkg::time_t t);
		send_item(cq_pkg::CMD_SCHEDULE, t, $urandom);
	endtask

	task automatic remove_one();
		send_item(cq_pkg::CMD_REMOVE, cq_pkg::time_t'({$urandom, $urandom}), $urandom);
	endtask

	function automatic cq_pkg::time_t pick_time();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return sb.last_time + cq_pkg::time_t'($urandom_range(0, 4 << cq_pkg::FRAC_BITS));
		if (sel < 9) return cq_pkg::time_t'({$urandom, $urandom});
		return (sel & 1) ? '1 : '0;
	endfunction

	task automatic mixed_items(int count, int sched_pct);
		for (int k = 0; k < count; k++) begin
			if (k % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < sched_pct) schedule_at(pick_time());
			else remove_one();
		end
	endtask

	// receiver: random stalls per result, one long hold-off on request
	initial begin
		int gap;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end
			gap = no_idle ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result({out_ch.status, out_ch.out_time, out_ch.out_payload,
				out_ch.pending_count});
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", idle_cycles);
			$display("FAIL calendar_event_queue");
			$finish;
		end
	end

	initial begin
		sb = new();
		idle_cycles = 0;
		no_idle = 0;
		hold_req = 0;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.cmd <= cq_pkg::CMD_SCHEDULE;
		in_ch.event_time <= '0;
		in_ch.event_payload <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, extremes of time and tag, equal times, year overflow
		remove_one();
		send_item(cq_pkg::CMD_SCHEDULE, '0, '0);
		send_item(cq_pkg::CMD_SCHEDULE, '1, '1);
		send_item(cq_pkg::CMD_SCHEDULE, 48'h0000_0001_8000, 32'h1234_5678);
		send_item(cq_pkg::CMD_SCHEDULE, 48'h0000_0001_8000, 32'h8765_4321);
		send_item(cq_pkg::CMD_SCHEDULE, 48'hFFFF_FFFF_0000, 32'hA5A5_A5A5);
		send_item(cq_pkg::CMD_SCHEDULE, 48'h0000_0000_FFFF, 32'h5A5A_5A5A);
		send_item(cq_pkg::CMD_SCHEDULE, 48'h8000_0000_0000, 32'h0000_0001);
		repeat (9) remove_one();
		send_item(cq_pkg::CMD_SCHEDULE, 48'h0000_0000_0001, 32'h8000_0000);
		send_item(cq_pkg::CMD_SCHEDULE, 48'h0000_0005_4000, 32'hFFFF_0000);
		remove_one();
		remove_one();

		hold_req = 1;
		mixed_items(80, 55);

		// fill the pool up to capacity and try a few more
		no_idle = 1;
		while (sb.held < cq_pkg::CAPACITY) schedule_at(pick_time());
		no_idle = 0;
		repeat (6) schedule_at(pick_time());

		mixed_items(40, 30);
		in_ch.valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("covered %0d results: %0d removals, %0d empty, %0d rejected, %0d rehashes",
			sb.checked, sb.n_removed, sb.n_empty, sb.n_full, sb.n_resize);
		$display("mismatches: %0d", sb.errors);
		if (sb.errors == 0)
			$display("PASS calendar_event_queue");
		else
			$display("FAIL calendar_event_queue");
		$finish;
	end
endmodule
